// File: rtl/vad_pkg.sv
// shared types, constants and tables of the vector angle unit
`timescale 1ns / 1ps
package vad_pkg;

  localparam int ELEM_BITS       = 16;
  localparam int ANGLE_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int WIDE_BITS       = 64;
  localparam int ROOT_BITS       = 32;
  localparam int QUO_BITS        = 34;
  localparam int COS_BITS        = 31;
  localparam int CORDIC_STEPS    = 22;
  localparam int ATAN_BITS       = 22;
  localparam int Z_BITS          = 25;
  localparam int XY_BITS         = 36;

  localparam logic [WIDE_BITS-1:0] NORM_LOW = 64'd1 << 60;
  localparam logic [COS_BITS-1:0]  ONE_Q30  = 31'h4000_0000;
  localparam logic signed [Z_BITS-1:0] NINETY_Q16     = 25'sd5898240;
  localparam logic signed [Z_BITS-1:0] ONE_EIGHTY_Q16 = 25'sd11796480;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_A   = 2'd1,
    ST_ZERO_B   = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // atan(2^-i) in degrees, q.16
  function automatic logic [ATAN_BITS-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_BITS-1:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // q.16 degrees to output format, round half up, saturate
  function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [Z_BITS-1:0] z);
    logic [Z_BITS-1:0] t;
    t = (z + (Z_BITS'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
    if (t > Z_BITS'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return t[ANGLE_BITS-1:0];
  endfunction

endpackage

// File: rtl/vector_angle_degrees_unit.sv
// top level: angle between two streamed vectors, in degrees
`timescale 1ns / 1ps
// Input channel: one beat per element pair (elem_a, elem_b, signed q1.15) with
// last marking the final pair. A beat is taken when in_valid is high and
// in_stall is low. Pairs accumulate at one beat per cycle while in_stall is low.
// Output channel: one beat per vector pair, angle in unsigned q8.8 degrees
// (0 .. 180) and status (ok, first vector zero, second vector zero, too many
// elements). The angle is zero whenever status is not ok.
// After the last beat the block holds in_stall high while a sequencer runs
// the final math on shared units: a two-bit shift normalizer, an iterative
// square root (used three times), a 32x32 multiplier (used twice), a
// bit-serial divider and a 22-step cordic. The normalizer shift counts of
// the two sums and the dot product range from 11 to 30; parallel vectors
// (zero sine) skip the cordic. Error cases and a zero dot product skip the
// final math and go straight to the output register; in_stall drops as the
// result is loaded.
// The result sits in an output register; the block accepts the next vector
// while it waits, and only stalls at the end of the next vector's math if
// the receiver still holds out_stall high.
// Synchronous reset clears the accumulators, the element count and the
// output valid.
module vector_angle_degrees_unit #(
  parameter int MAX_LEN = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] elem_a,
  input  logic signed [15:0] elem_b,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] angle,
  output logic [1:0]  status
);

  localparam int ACC_W = 2 * vad_pkg::ELEM_BITS + $clog2(MAX_LEN + 1);
  localparam int CNT_W = $clog2(MAX_LEN + 2);
  localparam int PAD_W = 64 - ACC_W;

  typedef enum logic [3:0] {
    S_ACC, S_CHECK, S_NORM_A, S_SQRT_A, S_NORM_B, S_SQRT_B, S_MUL, S_NORM_N,
    S_DIV, S_COS, S_MUL_C, S_SQRT_S, S_CORDIC, S_FIN, S_DONE
  } state_t;

  state_t state;

  // accumulators
  logic signed [ACC_W-1:0] sum_sq_a;
  logic signed [ACC_W-1:0] sum_sq_b;
  logic signed [ACC_W-1:0] sum_dot;
  logic [CNT_W-1:0]        elem_count;
  logic signed [31:0]      p_aa;
  logic signed [31:0]      p_bb;
  logic signed [31:0]      p_ab;
  logic                    in_accept;
  logic [ACC_W-1:0]        dot_mag;

  // final math datapath
  logic [63:0] norm_val;
  logic [4:0]  norm_k;
  logic        norm_done;
  logic [4:0]  ka;
  logic [4:0]  kb;
  logic [4:0]  kn;
  logic [31:0] root_a;
  logic [31:0] root_b;
  logic [63:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [vad_pkg::QUO_BITS-1:0] quo;
  logic [vad_pkg::COS_BITS-1:0] cos_q30;
  logic [vad_pkg::COS_BITS-1:0] cos_next;
  logic [vad_pkg::COS_BITS-1:0] sine;
  logic signed [7:0] cos_sh;
  logic [5:0]        cos_amt;
  logic [vad_pkg::QUO_BITS-1:0] cos_shifted;
  logic        dot_neg;
  logic signed [vad_pkg::Z_BITS-1:0] z_val;
  logic signed [vad_pkg::Z_BITS-1:0] z_clamp;
  logic signed [vad_pkg::Z_BITS-1:0] z_mir;
  logic [15:0]            res_angle;
  vad_pkg::status_t       res_status;

  // shared unit handshakes
  logic        sq_start;
  logic        sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic        div_start;
  logic        div_done;
  logic [vad_pkg::QUO_BITS-1:0] div_q;
  logic        cor_start;
  logic        cor_done;
  logic signed [vad_pkg::Z_BITS-1:0] cor_z;

  assign in_stall  = (state != S_ACC);
  assign in_accept = in_valid && !in_stall;

  assign p_aa = elem_a * elem_a;
  assign p_bb = elem_b * elem_b;
  assign p_ab = elem_a * elem_b;

  assign dot_mag   = sum_dot[ACC_W-1] ? ACC_W'(-sum_dot) : ACC_W'(sum_dot);
  assign norm_done = (norm_val[63:60] != 4'd0);

  // one multiplier, shared by the root product and the cosine square
  assign mul_a = (state == S_MUL_C) ? {1'b0, cos_q30} : root_a;
  assign mul_b = (state == S_MUL_C) ? {1'b0, cos_q30} : root_b;
  assign mul_p = mul_a * mul_b;

  // square root unit reads a normalized sum or the sine radicand
  assign sq_in = (state == S_SQRT_S) ? (vad_pkg::NORM_LOW - prod) : norm_val;

  // cosine exponent: quotient scaled by 2^(ka + kb - 2*kn - 2)
  assign cos_sh = $signed({3'b000, ka}) + $signed({3'b000, kb})
                - $signed({2'b00, kn, 1'b0}) - 8'sd2;
  assign cos_amt     = 6'(-cos_sh);
  assign cos_shifted = quo >> cos_amt;
  always_comb begin
    if (!cos_sh[7]) begin
      cos_next = vad_pkg::ONE_Q30;
    end else if (cos_shifted > vad_pkg::QUO_BITS'(vad_pkg::ONE_Q30)) begin
      cos_next = vad_pkg::ONE_Q30;
    end else begin
      cos_next = cos_shifted[vad_pkg::COS_BITS-1:0];
    end
  end

  // clamp to a quarter turn, mirror for an obtuse angle
  always_comb begin
    if (z_val[vad_pkg::Z_BITS-1]) begin
      z_clamp = '0;
    end else if (z_val > vad_pkg::NINETY_Q16) begin
      z_clamp = vad_pkg::NINETY_Q16;
    end else begin
      z_clamp = z_val;
    end
    z_mir = dot_neg ? (vad_pkg::ONE_EIGHTY_Q16 - z_clamp) : z_clamp;
  end

  vad_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  vad_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (norm_val),
    .den   (prod),
    .done  (div_done),
    .quo   (div_q)
  );

  vad_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .cos_in (cos_q30),
    .sin_in (sine),
    .done   (cor_done),
    .z      (cor_z)
  );

  always_ff @(posedge clk) begin
    sq_start  <= 1'b0;
    div_start <= 1'b0;
    cor_start <= 1'b0;
    if (rst) begin
      state      <= S_ACC;
      sum_sq_a   <= '0;
      sum_sq_b   <= '0;
      sum_dot    <= '0;
      elem_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_ACC: begin
          if (in_accept) begin
            sum_sq_a <= sum_sq_a + ACC_W'(p_aa);
            sum_sq_b <= sum_sq_b + ACC_W'(p_bb);
            sum_dot  <= sum_dot + ACC_W'(p_ab);
            if (elem_count <= CNT_W'(MAX_LEN)) begin
              elem_count <= elem_count + CNT_W'(1);
            end
            if (last) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          dot_neg <= sum_dot[ACC_W-1];
          priority if (elem_count > CNT_W'(MAX_LEN)) begin
            res_status <= vad_pkg::ST_TOO_LONG;
            res_angle  <= '0;
            state      <= S_DONE;
          end else if (sum_sq_a == '0) begin
            res_status <= vad_pkg::ST_ZERO_A;
            res_angle  <= '0;
            state      <= S_DONE;
          end else if (sum_sq_b == '0) begin
            res_status <= vad_pkg::ST_ZERO_B;
            res_angle  <= '0;
            state      <= S_DONE;
          end else if (sum_dot == '0) begin
            res_status <= vad_pkg::ST_OK;
            res_angle  <= vad_pkg::round_angle(vad_pkg::NINETY_Q16);
            state      <= S_DONE;
          end else begin
            norm_val <= {{PAD_W{1'b0}}, sum_sq_a};
            norm_k   <= '0;
            state    <= S_NORM_A;
          end
        end
        S_NORM_A: begin
          if (norm_done) begin
            ka       <= norm_k;
            sq_start <= 1'b1;
            state    <= S_SQRT_A;
          end else begin
            norm_val <= norm_val << 2;
            norm_k   <= norm_k + 5'd1;
          end
        end
        S_SQRT_A: begin
          if (sq_done) begin
            root_a   <= sq_root;
            norm_val <= {{PAD_W{1'b0}}, sum_sq_b};
            norm_k   <= '0;
            state    <= S_NORM_B;
          end
        end
        S_NORM_B: begin
          if (norm_done) begin
            kb       <= norm_k;
            sq_start <= 1'b1;
            state    <= S_SQRT_B;
          end else begin
            norm_val <= norm_val << 2;
            norm_k   <= norm_k + 5'd1;
          end
        end
        S_SQRT_B: begin
          if (sq_done) begin
            root_b <= sq_root;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod     <= mul_p;
          norm_val <= {{PAD_W{1'b0}}, dot_mag};
          norm_k   <= '0;
          state    <= S_NORM_N;
        end
        S_NORM_N: begin
          if (norm_done) begin
            kn        <= norm_k;
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            norm_val <= norm_val << 2;
            norm_k   <= norm_k + 5'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            quo   <= div_q;
            state <= S_COS;
          end
        end
        S_COS: begin
          cos_q30 <= cos_next;
          state   <= S_MUL_C;
        end
        S_MUL_C: begin
          prod     <= mul_p;
          sq_start <= 1'b1;
          state    <= S_SQRT_S;
        end
        S_SQRT_S: begin
          if (sq_done) begin
            sine <= sq_root[vad_pkg::COS_BITS-1:0];
            if (sq_root == '0) begin
              // parallel vectors
              z_val <= '0;
              state <= S_FIN;
            end else begin
              cor_start <= 1'b1;
              state     <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (cor_done) begin
            z_val <= cor_z;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_angle  <= vad_pkg::round_angle(z_mir);
          res_status <= vad_pkg::ST_OK;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            angle      <= res_angle;
            status     <= 2'(res_status);
            sum_sq_a   <= '0;
            sum_sq_b   <= '0;
            sum_dot    <= '0;
            elem_count <= '0;
            state      <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

endmodule

// File: rtl/vad_isqrt.sv
// iterative floor square root, two radicand bits per cycle
`timescale 1ns / 1ps
module vad_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [4:0]  idx;
  logic        busy;
  logic [63:0] bit_val;
  logic [63:0] trial;

  assign bit_val = 64'd1 << {idx, 1'b0};
  assign trial   = res + bit_val;
  assign root    = res[31:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem  <= radicand;
      res  <= '0;
      idx  <= 5'd31;
      busy <= 1'b1;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bit_val;
      end else begin
        res <= res >> 1;
      end
      if (idx == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        idx <= idx - 5'd1;
      end
    end
  end

endmodule

// File: rtl/vad_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module vad_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [63:0]                   num,
  input  logic [63:0]                   den,
  output logic                          done,
  output logic [vad_pkg::QUO_BITS-1:0]  quo
);

  logic [63:0] rem;
  logic [63:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic        ge;

  assign ge = rem >= dsr;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem  <= num;
      dsr  <= den << 1;
      quo  <= '0;
      cnt  <= 6'(vad_pkg::QUO_BITS - 1);
      busy <= 1'b1;
    end else if (busy) begin
      rem <= (ge ? rem - dsr : rem) << 1;
      quo <= {quo[vad_pkg::QUO_BITS-2:0], ge};
      if (cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

endmodule

// File: rtl/vad_cordic.sv
// cordic vectoring, one rotation per cycle, angle in q.16 degrees
`timescale 1ns / 1ps
module vad_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [vad_pkg::COS_BITS-1:0]        cos_in,
  input  logic [vad_pkg::COS_BITS-1:0]        sin_in,
  output logic                                done,
  output logic signed [vad_pkg::Z_BITS-1:0]   z
);

  logic signed [vad_pkg::XY_BITS-1:0] x;
  logic signed [vad_pkg::XY_BITS-1:0] y;
  logic signed [vad_pkg::XY_BITS-1:0] dx;
  logic signed [vad_pkg::XY_BITS-1:0] dy;
  logic signed [vad_pkg::Z_BITS-1:0]  at;
  logic [4:0] idx;
  logic       busy;

  assign dx = y >>> idx;
  assign dy = x >>> idx;
  assign at = $signed({3'b000, vad_pkg::atan_deg(idx)});

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      x    <= $signed({5'b00000, cos_in});
      y    <= $signed({5'b00000, sin_in});
      z    <= '0;
      idx  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (!y[vad_pkg::XY_BITS-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end
      if (idx == 5'(vad_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        idx <= idx + 5'd1;
      end
    end
  end

endmodule

// File: rtl/vad_checker.sv
// port-level assertions for the vector angle unit, bound to the top level
`timescale 1ns / 1ps
module vad_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic signed [15:0] elem_a,
  input logic signed [15:0] elem_b,
  input logic        last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] angle,
  input logic [1:0]  status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle) && $stable(status))
    else $error("result beat changed while stalled");

  // error results carry a zero angle
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != 2'(vad_pkg::ST_OK)) |-> angle == 16'd0)
    else $error("nonzero angle with error status");

  // angle never beyond half a turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle <= 16'd46080)
    else $error("angle out of range");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector_angle_degrees_unit vad_checker u_vad_checker (.*);

// File: tb/vector_angle_degrees_unit_test.sv
// testbench of the vector angle unit: directed table and length-limit vectors, then random vectors
`timescale 1ns / 1ps
module vector_angle_degrees_unit_test;

  // directed rows: a negative expected angle means "take the prediction"
  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               fin;
    int                 want_angle;
    vad_pkg::status_t   want_status;
  } row_t;

  typedef struct {
    logic [15:0]      angle;
    vad_pkg::status_t status;
  } angle_res_t;

  localparam int MAX_PAIRS  = 256;
  localparam int ROWS       = 16;
  localparam int TAIL_WAIT  = 400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic last;
  logic out_valid;
  logic out_stall;
  logic [15:0] angle;
  logic [1:0] status;

  // predictor copy of the accumulators
  longint sq_sum_a, sq_sum_b, dot_sum;
  int     pairs_seen;

  angle_res_t pending_angles[$];
  int idle_in_pct, idle_out_pct;
  int mismatches, vectors_sent, pairs_sent, results_seen;
  row_t dir_rows[ROWS];
  logic signed [15:0] elem_keep_a, elem_keep_b;

  vector_angle_degrees_unit #(.MAX_LEN(MAX_PAIRS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .elem_a(elem_a), .elem_b(elem_b), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle(angle), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d angles still pending", pending_angles.size());
    $display("Simulation FAILED");
    $finish;
  end

  // floor integer square root, digit by digit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // mantissa into [2^60, 2^62) with an even exponent
  function automatic longint unsigned norm_mant(input longint unsigned v, output int ex);
    ex = 0;
    while (v >= (64'd1 << 62)) begin
      v >>= 2;
      ex += 2;
    end
    while (v < (64'd1 << 60)) begin
      v <<= 2;
      ex -= 2;
    end
    return v;
  endfunction

  // cosine in unsigned q1.30, clamped to one
  function automatic longint unsigned cos_q30(input longint unsigned sa,
                                              input longint unsigned sb,
                                              input longint unsigned n);
    int ea, eb, en, sh;
    longint unsigned ra, rb, r, mn, q, rem, c;
    ra = int_sqrt(norm_mant(sa, ea));
    rb = int_sqrt(norm_mant(sb, eb));
    r = ra * rb;
    mn = norm_mant(n, en);
    q = mn / r;
    rem = mn % r;
    for (int i = 0; i < 32; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= r) begin
        rem -= r;
        q |= 64'd1;
      end
    end
    sh = en - (ea / 2 + eb / 2) - 2;
    if (sh >= 0) c = (sh > 30) ? 64'd1 << 30 : q << sh;
    else c = (-sh >= 64) ? 64'd0 : q >> (-sh);
    return (c > (64'd1 << 30)) ? 64'd1 << 30 : c;
  endfunction

  // vectoring cordic, degrees in q.16, clamped to [0, 90]
  function automatic longint cordic_deg(input longint c, input longint s);
    longint x, y, z, dx, dy;
    x = c;
    y = s;
    z = 0;
    for (int i = 0; i < vad_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(vad_pkg::atan_deg(5'(i)));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(vad_pkg::atan_deg(5'(i)));
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return z;
  endfunction

  function automatic logic [15:0] to_q8_8(input longint z);
    longint v;
    v = (z + 128) >>> 8;
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // fold in one pair; returns 1 with the expected angle on the final pair
  function automatic bit predict_angle(input logic signed [15:0] a,
                                       input logic signed [15:0] b,
                                       input logic fin, output angle_res_t res);
    longint av, bv, z;
    longint unsigned n, c, s;
    bit neg;
    av = a;
    bv = b;
    sq_sum_a += av * av;
    sq_sum_b += bv * bv;
    dot_sum += av * bv;
    if (pairs_seen <= MAX_PAIRS) pairs_seen++;
    res.angle = '0;
    res.status = vad_pkg::ST_OK;
    if (!fin) return 1'b0;
    if (pairs_seen > MAX_PAIRS) begin
      res.status = vad_pkg::ST_TOO_LONG;
    end else if (sq_sum_a == 0) begin
      res.status = vad_pkg::ST_ZERO_A;
    end else if (sq_sum_b == 0) begin
      res.status = vad_pkg::ST_ZERO_B;
    end else if (dot_sum == 0) begin
      res.angle = to_q8_8(90 * 65536);
    end else begin
      neg = dot_sum < 0;
      n = neg ? -dot_sum : dot_sum;
      c = cos_q30(sq_sum_a, sq_sum_b, n);
      s = int_sqrt((64'd1 << 60) - c * c);
      z = (s == 0) ? 0 : cordic_deg(c, s);
      if (neg) z = 180 * 65536 - z;
      res.angle = to_q8_8(z);
    end
    sq_sum_a = 0;
    sq_sum_b = 0;
    dot_sum = 0;
    pairs_seen = 0;
    return 1'b1;
  endfunction

  // drive one beat, wait for it to be taken, record the expected angle
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic fin, input int want_angle = -1,
                           input vad_pkg::status_t want_status = vad_pkg::ST_OK);
    angle_res_t res;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    elem_a <= a;
    elem_b <= b;
    last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
    if (predict_angle(a, b, fin, res)) begin
      // a nonnegative typed-in angle overrides the prediction
      if (want_angle >= 0) begin
        res.angle = 16'(want_angle);
        res.status = want_status;
      end
      pending_angles.insert(pending_angles.size(), res);
      vectors_sent++;
    end
  endtask

  // sender holds off until every pending angle has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // random vectors: mostly short, some full length, a few too long
  task automatic random_vectors(input int n_pairs);
    int start, len, kind, mode;
    logic signed [15:0] a, b;
    start = pairs_sent;
    while (pairs_sent - start < n_pairs) begin
      kind = $urandom_range(99);
      mode = $urandom_range(9);
      if (kind < 2) len = $urandom_range(MAX_PAIRS - 8, MAX_PAIRS);
      else if (kind < 4) len = $urandom_range(MAX_PAIRS + 1, MAX_PAIRS + 20);
      else len = $urandom_range(1, 8);
      if (mode == 4) len = 2;
      for (int i = 0; i < len; i++) begin
        a = 16'($urandom);
        b = 16'($urandom);
        case (mode)
          1: a = '0;                                   // first vector zero
          2: b = '0;                                   // second vector zero
          3: b = a;                                    // parallel
          4: begin                                     // orthogonal pair
            if (i == 0) begin
              a = 16'($urandom);
              b = 16'($urandom);
              elem_keep_a = a;
              elem_keep_b = b;
            end else begin
              a = elem_keep_b;
              b = -elem_keep_a;
            end
          end
          5: b = -a;                                   // opposed
          6: begin                                     // tiny magnitudes
            a = 16'($signed($urandom_range(0, 6)) - 3);
            b = 16'($signed($urandom_range(0, 6)) - 3);
          end
          default: ;
        endcase
        send_pair(a, b, i == len - 1);
      end
    end
  endtask

  // result side: random stalls and in-order check against the pending angles
  always @(posedge clk) begin
    angle_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: angle %0d status %0d", angle, status);
      end else begin
        want = pending_angles.pop_front();
        if (angle !== want.angle || status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vector %0d: expected angle %0d status %0d, got angle %0d status %0d",
                     results_seen, want.angle, want.status, angle, status);
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_out_pct);
  end

  initial begin
    int waited;
    // directed rows: error codes, extremes, right angles
    dir_rows = '{
      '{16'sd0, 16'sd5, 1'b1, 0, vad_pkg::ST_ZERO_A},
      '{16'sd7, 16'sd0, 1'b1, 0, vad_pkg::ST_ZERO_B},
      '{16'sd0, 16'sd0, 1'b1, 0, vad_pkg::ST_ZERO_A},
      '{16'sd32767, 16'sd32767, 1'b1, 0, vad_pkg::ST_OK},
      '{16'sd32767, -16'sd32767, 1'b1, 46080, vad_pkg::ST_OK},
      '{-16'sd32768, -16'sd32768, 1'b1, 0, vad_pkg::ST_OK},
      '{16'sd32767, -16'sd32768, 1'b1, -1, vad_pkg::ST_OK},
      '{-16'sd32768, 16'sd32767, 1'b1, -1, vad_pkg::ST_OK},
      '{16'sd1, 16'sd0, 1'b0, -1, vad_pkg::ST_OK},
      '{16'sd0, 16'sd1, 1'b1, 23040, vad_pkg::ST_OK},
      '{16'sd1, 16'sd1, 1'b0, -1, vad_pkg::ST_OK},
      '{16'sd1, -16'sd1, 1'b1, 23040, vad_pkg::ST_OK},
      '{16'sd100, 16'sd200, 1'b0, -1, vad_pkg::ST_OK},
      '{16'sd300, -16'sd50, 1'b1, -1, vad_pkg::ST_OK},
      '{-16'sd1, 16'sd1, 1'b0, -1, vad_pkg::ST_OK},
      '{16'sd2, 16'sd3, 1'b1, -1, vad_pkg::ST_OK}
    };
    rst = 1'b1;
    in_valid = 1'b0;
    elem_a = '0;
    elem_b = '0;
    last = 1'b0;
    elem_keep_a = '0;
    elem_keep_b = '0;
    sq_sum_a = 0;
    sq_sum_b = 0;
    dot_sum = 0;
    pairs_seen = 0;
    mismatches = 0;
    vectors_sent = 0;
    pairs_sent = 0;
    results_seen = 0;
    idle_in_pct = 21;
    idle_out_pct = 71;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++)
      send_pair(dir_rows[r].a, dir_rows[r].b, dir_rows[r].fin,
                dir_rows[r].want_angle, dir_rows[r].want_status);
    // one pair past the limit gives the too-long code
    for (int i = 0; i < MAX_PAIRS; i++) send_pair(16'sd3, -16'sd4, 1'b0);
    send_pair(16'sd3, 16'sd4, 1'b1, 0, vad_pkg::ST_TOO_LONG);
    // exactly at the limit is still fine
    for (int i = 0; i < MAX_PAIRS - 1; i++) send_pair(16'($urandom), 16'($urandom), 1'b0);
    send_pair(16'($urandom), 16'($urandom), 1'b1);
    drain();

    random_vectors(390);
    drain();
    idle_in_pct = 71;
    idle_out_pct = 21;
    random_vectors(390);
    drain();
    idle_in_pct = 0;
    idle_out_pct = 0;
    random_vectors(390);
    in_valid <= 1'b0;

    // wait out the math of the final vector, then a margin
    waited = 0;
    while (pending_angles.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_WAIT) @(posedge clk);

    $display("sent %0d element pairs in %0d vectors, checked %0d angles",
             pairs_sent, vectors_sent, results_seen);
    $display("covered zero vectors, over-long vectors, parallel, opposed and right angles");
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d angles never arrived", mismatches, pending_angles.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/vad_pkg.sv
rtl/vad_isqrt.sv
rtl/vad_div.sv
rtl/vad_cordic.sv
rtl/vector_angle_degrees_unit.sv
rtl/vad_checker.sv
tb/vector_angle_degrees_unit_test.sv
